### rtl/core/dmm_pkg.sv
package dmm_pkg;

    // Field widths of the stream payloads
    localparam int ACTION_BITS   = 2;
    localparam int INDEX_BITS    = 4;
    localparam int VALUE_BITS    = 16;
    localparam int PRODUCT_BITS  = 41;
    localparam int SIZE_BITS     = 5;
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 56;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - PRODUCT_BITS - 2 * INDEX_BITS;

    // Request kinds carried on tuser
    localparam logic [ACTION_BITS-1:0] ACT_WRITE_A = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_WRITE_B = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ    = 2'd2;

    // Size register value after reset
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;  // zero the accumulator
        logic valid;  // operand pair present this cycle
    } t_mac_ctl;

endpackage

### rtl/core/dmm_store.sv
module dmm_store
    import dmm_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    // Write one element
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/dmm_mac.sv
module dmm_mac
    import dmm_pkg::*;
#(
    parameter int ELEMENT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_mac_ctl                       i_ctl,
    input  logic [ELEMENT_BITS-1:0]        i_a,
    input  logic [ELEMENT_BITS-1:0]        i_b,
    output logic signed [PRODUCT_BITS-1:0] o_acc
);

    logic signed [2*ELEMENT_BITS-1:0] r_prod;
    logic                             r_prod_valid;
    logic signed [PRODUCT_BITS-1:0]   r_acc;

    // Track which product register holds a real term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.valid;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_a) * $signed(i_b);
    end

    // Accumulate stage, wrapping at the result width
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_valid) begin
            r_acc <= r_acc + PRODUCT_BITS'(r_prod);
        end
    end

    assign o_acc = r_acc;

    // A new dot product never starts while a term is still entering
    a_clear_not_with_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |-> !i_ctl.valid && !r_prod_valid)
        else $error("accumulator cleared while a term is in flight");

endmodule

### rtl/core/dense_matrix_multiply.sv
// Writes (tuser 0 or 1) go straight to the stores. A read (tuser 2) holds tready low until it is
// answered: the walk takes n terms of row and column, n the clamped size in use, through the shared
// multiply-accumulate unit, then the read, multiply and accumulate registers drain. A read outside
// the size skips the walk; an untaken result stalls the input. Reset (synchronous, active low) idles
// the sequencer, drops the result and sets the size to 16; the matrix stores are not cleared and hold
// garbage until written.
module dense_matrix_multiply
    import dmm_pkg::*;
#(
    parameter int MAX_SIZE     = 16,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Size register write
    input  logic                     i_cfg_wr_en,
    input  logic [SIZE_BITS-1:0]     i_cfg_wr_data,
    // Request stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [ACTION_BITS-1:0]   s_axis_tuser,  // action
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // row[3:0], col[7:4], value[23:8]
    // Result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata   // product_value[40:0], result_row[44:41],
                                                    // result_col[48:45], zero pad
);

    localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int LEN_BITS   = $clog2(MAX_SIZE + 1);
    localparam int USED_BITS  = (ELEMENT_BITS < VALUE_BITS) ? ELEMENT_BITS : VALUE_BITS;
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    t_state                   r_state, n_state;
    logic [LEN_BITS-1:0]      r_k, n_k;
    logic [LEN_BITS-1:0]      r_len, n_len;
    logic [ADDR_BITS-1:0]     r_a_addr, n_a_addr;
    logic [ADDR_BITS-1:0]     r_b_addr, n_b_addr;
    logic [1:0]               r_drain, n_drain;
    logic                     r_rd_valid;
    logic [SIZE_BITS-1:0]     r_size;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data, n_out_data;
    logic [INDEX_BITS-1:0]    r_row, n_row;
    logic [INDEX_BITS-1:0]    r_col, n_col;

    logic [INDEX_BITS-1:0]    w_row;
    logic [INDEX_BITS-1:0]    w_col;
    logic [VALUE_BITS-1:0]    w_value;
    logic [ELEMENT_BITS-1:0]  w_elem;
    logic                     w_accept;
    logic                     w_wr_ok;
    logic                     w_wr_a;
    logic                     w_wr_b;
    logic [ADDR_BITS-1:0]     w_wr_addr;
    logic [LEN_BITS-1:0]      w_eff_len;
    logic                     w_in_range;
    logic                     w_rd_en;
    logic [ELEMENT_BITS-1:0]  w_a_data;
    logic [ELEMENT_BITS-1:0]  w_b_data;
    logic signed [PRODUCT_BITS-1:0] w_acc;
    t_mac_ctl                 w_mac_ctl;

    // Unpack the request
    assign w_row   = s_axis_tdata[INDEX_BITS-1:0];
    assign w_col   = s_axis_tdata[2*INDEX_BITS-1:INDEX_BITS];
    assign w_value = s_axis_tdata[2*INDEX_BITS+VALUE_BITS-1:2*INDEX_BITS];
    assign w_elem  = ELEMENT_BITS'($signed(w_value[USED_BITS-1:0]));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Element writes, dropped when outside the store
    assign w_wr_ok   = (int'(w_row) < MAX_SIZE) && (int'(w_col) < MAX_SIZE);
    assign w_wr_a    = w_accept && (s_axis_tuser == ACT_WRITE_A) && w_wr_ok;
    assign w_wr_b    = w_accept && (s_axis_tuser == ACT_WRITE_B) && w_wr_ok;
    assign w_wr_addr = ADDR_BITS'(int'(w_row) * MAX_SIZE + int'(w_col));

    // Clamp the size in use to 1..MAX_SIZE
    always_comb begin
        if (r_size == '0) begin
            w_eff_len = LEN_BITS'(1);
        end else if (int'(r_size) > MAX_SIZE) begin
            w_eff_len = LEN_BITS'(MAX_SIZE);
        end else begin
            w_eff_len = LEN_BITS'(r_size);
        end
    end

    assign w_in_range = (int'(w_row) < int'(w_eff_len)) && (int'(w_col) < int'(w_eff_len));

    assign w_rd_en   = (r_state == ST_ISSUE);
    assign w_mac_ctl = '{clear: (w_accept && (s_axis_tuser == ACT_READ)), valid: r_rd_valid};

    dmm_store #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (ELEMENT_BITS)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_a),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_elem),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_a_addr),
        .o_rd_data (w_a_data)
    );

    dmm_store #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (ELEMENT_BITS)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_b),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_elem),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_b_addr),
        .o_rd_data (w_b_data)
    );

    dmm_mac #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_a_data),
        .i_b     (w_b_data),
        .o_acc   (w_acc)
    );

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_len       = r_len;
        n_a_addr    = r_a_addr;
        n_b_addr    = r_b_addr;
        n_drain     = r_drain;
        n_row       = r_row;
        n_col       = r_col;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // Release the result once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept && (s_axis_tuser == ACT_READ)) begin
                    n_row    = w_row;
                    n_col    = w_col;
                    n_len    = w_eff_len;
                    n_k      = '0;
                    n_drain  = '0;
                    n_a_addr = ADDR_BITS'(int'(w_row) * MAX_SIZE);
                    n_b_addr = ADDR_BITS'(w_col);
                    // Outside the size: skip the walk, the cleared sum gives zero
                    n_state  = w_in_range ? ST_ISSUE : ST_DRAIN;
                end
            end
            ST_ISSUE: begin
                // Advance along row of A and column of B
                n_a_addr = r_a_addr + ADDR_BITS'(1);
                n_b_addr = r_b_addr + ADDR_BITS'(MAX_SIZE);
                n_k      = r_k + LEN_BITS'(1);
                if (r_k + LEN_BITS'(1) == r_len) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain != DRAIN_LAST) begin
                    n_drain = r_drain + 2'd1;
                end else if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {OUT_PAD_BITS'(0), r_col, r_row, w_acc};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_drain     <= '0;
            r_rd_valid  <= 1'b0;
            r_size      <= SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_drain     <= n_drain;
            r_rd_valid  <= w_rd_en;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
        end
        r_len      <= n_len;
        r_a_addr   <= n_a_addr;
        r_b_addr   <= n_b_addr;
        r_row      <= n_row;
        r_col      <= n_col;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The walk never runs past the length in use
    a_k_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_k < r_len))
        else $error("term index beyond length in use");

    // The last store read has been consumed before the result is taken
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && r_drain == DRAIN_LAST) |-> !r_rd_valid)
        else $error("result taken with a term still in flight");

    // A result appears only at the end of the drain
    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_DRAIN))
        else $error("result raised outside the drain");

    // A read in the walk is followed by its data in the next cycle
    a_read_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |=> r_rd_valid)
        else $error("store read without read data");

endmodule

### dv/dense_matrix_multiply_tb.sv
module dense_matrix_multiply_tb
    import dmm_pkg::*;
;

    localparam int MATRIX_DIM   = 16;
    localparam int DRAIN_CYCLES = 32;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 92;
    localparam int NUM_PHASES   = 9;

    // Action code that the block ignores
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [PRODUCT_BITS-1:0] product;
        logic [INDEX_BITS-1:0]   row;
        logic [INDEX_BITS-1:0]   col;
    } t_product_entry;

    // Mirror of both matrices and the size register; queue of expected products
    class product_scoreboard;
        logic signed [VALUE_BITS-1:0] left_elems [MATRIX_DIM][MATRIX_DIM];
        logic signed [VALUE_BITS-1:0] right_elems [MATRIX_DIM][MATRIX_DIM];
        logic [SIZE_BITS-1:0]         size_reg;
        t_product_entry               pending [$];
        int                           errors;
        int                           reads_checked;
        int                           writes_seen;

        function new();
            foreach (left_elems[r, c]) begin
                left_elems[r][c]  = '0;
                right_elems[r][c] = '0;
            end
            size_reg      = SIZE_RESET;
            errors        = 0;
            reads_checked = 0;
            writes_seen   = 0;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // Apply an accepted request: store an element or queue the dot product
        function void note_request(logic [ACTION_BITS-1:0] act, logic [IN_DATA_BITS-1:0] data);
            logic [INDEX_BITS-1:0]          row;
            logic [INDEX_BITS-1:0]          col;
            logic signed [VALUE_BITS-1:0]   val;
            logic signed [PRODUCT_BITS-1:0] acc;
            t_product_entry                 entry;
            int                             n;
            int                             k;
            row = data[INDEX_BITS-1:0];
            col = data[2*INDEX_BITS-1:INDEX_BITS];
            val = data[IN_DATA_BITS-1:2*INDEX_BITS];
            case (act)
                ACT_WRITE_A: begin
                    left_elems[row][col] = val;
                    writes_seen++;
                end
                ACT_WRITE_B: begin
                    right_elems[row][col] = val;
                    writes_seen++;
                end
                ACT_READ: begin
                    // Clamp the size: zero acts as one, anything above the store as the store
                    n = (size_reg == 0) ? 1 : (size_reg > MATRIX_DIM) ? MATRIX_DIM : size_reg;
                    acc = '0;
                    if (row < n && col < n) begin
                        for (k = 0; k < n; k++)
                            acc = acc + left_elems[row][k] * right_elems[k][col];
                    end
                    entry.product = acc;
                    entry.row     = row;
                    entry.col     = col;
                    pending.push_back(entry);
                end
                default: ;
            endcase
        endfunction

        // Compare one returned product with the oldest expectation
        function void check_result(logic [OUT_DATA_BITS-1:0] data);
            t_product_entry got;
            t_product_entry want;
            got.product = data[PRODUCT_BITS-1:0];
            got.row     = data[PRODUCT_BITS +: INDEX_BITS];
            got.col     = data[PRODUCT_BITS+INDEX_BITS +: INDEX_BITS];
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected product: actual value %0d row %0d col %0d",
                         $time, $signed(got.product), got.row, got.col);
                return;
            end
            want = pending.pop_front();
            reads_checked++;
            if (got.product != want.product || got.row != want.row || got.col != want.col) begin
                errors++;
                $display("%0t: product mismatch: expected %0d (%0d,%0d), actual %0d (%0d,%0d)",
                         $time, $signed(want.product), want.row, want.col,
                         $signed(got.product), got.row, got.col);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [SIZE_BITS-1:0]     i_cfg_wr_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [ACTION_BITS-1:0]   s_axis_tuser;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    product_scoreboard sb = new();

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  items_sent    = 0;
    int  stall_count   = 0;
    logic [SIZE_BITS-1:0] cur_size = SIZE_RESET;
    bit  a_written [MATRIX_DIM][MATRIX_DIM];
    bit  b_written [MATRIX_DIM][MATRIX_DIM];

    dense_matrix_multiply uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stall the result stream at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Observe both streams at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count == STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic int clamped_size(logic [SIZE_BITS-1:0] v);
        return (v == 0) ? 1 : (v > MATRIX_DIM) ? MATRIX_DIM : v;
    endfunction

    // Mostly inside the size in use, sometimes anywhere
    function automatic logic [INDEX_BITS-1:0] pick_index(int n);
        if ($urandom_range(99) < 80)
            return INDEX_BITS'($urandom_range(n - 1, 0));
        return INDEX_BITS'($urandom_range(MATRIX_DIM - 1, 0));
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(24))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // Present one request, idling first at random, and hold it until accepted
    task automatic send_request(input logic [ACTION_BITS-1:0] act,
                                input logic [INDEX_BITS-1:0] row,
                                input logic [INDEX_BITS-1:0] col,
                                input logic [VALUE_BITS-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {val, col, row};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        if (act == ACT_WRITE_A)
            a_written[row][col] = 1'b1;
        if (act == ACT_WRITE_B)
            b_written[row][col] = 1'b1;
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    // Drain the block, then write the size register
    task automatic set_size(input logic [SIZE_BITS-1:0] v);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.size_reg   = v;
        cur_size      = v;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 32;
                recv_idle_pct = 74;
            end
            1: begin
                send_idle_pct = 74;
                recv_idle_pct = 32;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Random writes and reads; fill the needed row of A and column of B before a read
    task automatic run_random_phase(input int budget);
        int n;
        int start;
        int pick;
        int k;
        logic [INDEX_BITS-1:0] r;
        logic [INDEX_BITS-1:0] c;
        n = clamped_size(cur_size);
        start = items_sent;
        while (items_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_request(ACT_UNUSED, INDEX_BITS'($urandom), INDEX_BITS'($urandom),
                             VALUE_BITS'($urandom));
            end else if (pick < 73) begin
                send_request((pick < 38) ? ACT_WRITE_A : ACT_WRITE_B,
                             pick_index(n), pick_index(n), pick_value());
            end else begin
                r = pick_index(n);
                c = pick_index(n);
                if (r < n && c < n) begin
                    for (k = 0; k < n; k++) begin
                        if (!a_written[r][k])
                            send_request(ACT_WRITE_A, r, INDEX_BITS'(k), pick_value());
                        if (!b_written[k][c])
                            send_request(ACT_WRITE_B, INDEX_BITS'(k), c, pick_value());
                    end
                end
                send_request(ACT_READ, r, c, VALUE_BITS'($urandom));
            end
        end
    endtask

    initial begin
        logic [SIZE_BITS-1:0] phase_sizes [NUM_PHASES];
        int p;
        phase_sizes = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd3, 5'd17, 5'd7, 5'd2, 5'd16};
        phase_sizes[6] = SIZE_BITS'($urandom_range(31, 0));

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = ACT_WRITE_A;
        s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme values at size two, ignored action, reads outside the size
        set_idling(2);
        set_size(5'd2);
        send_request(ACT_WRITE_A, 4'd0, 4'd0, 16'h8000);
        send_request(ACT_WRITE_A, 4'd0, 4'd1, 16'h8000);
        send_request(ACT_WRITE_B, 4'd0, 4'd0, 16'h8000);
        send_request(ACT_WRITE_B, 4'd1, 4'd0, 16'h8000);
        send_request(ACT_READ,    4'd0, 4'd0, 16'hffff);
        send_request(ACT_WRITE_A, 4'd1, 4'd0, 16'h7fff);
        send_request(ACT_WRITE_A, 4'd1, 4'd1, 16'h8000);
        send_request(ACT_WRITE_B, 4'd0, 4'd1, 16'h7fff);
        send_request(ACT_WRITE_B, 4'd1, 4'd1, 16'h7fff);
        send_request(ACT_READ,    4'd0, 4'd1, 16'h0000);
        send_request(ACT_READ,    4'd1, 4'd0, 16'h0000);
        send_request(ACT_READ,    4'd1, 4'd1, 16'h0000);
        send_request(ACT_UNUSED,  4'd15, 4'd15, 16'hffff);
        send_request(ACT_WRITE_A, 4'd15, 4'd15, 16'h7fff);
        send_request(ACT_WRITE_B, 4'd15, 4'd15, 16'hffff);
        send_request(ACT_WRITE_A, 4'd0, 4'd15, 16'h0000);
        send_request(ACT_WRITE_B, 4'd15, 4'd0, 16'h0001);
        send_request(ACT_READ,    4'd2, 4'd0, 16'h1234);
        send_request(ACT_READ,    4'd15, 4'd15, 16'hffff);
        send_request(ACT_READ,    4'd0, 4'd15, 16'h8000);
        send_request(ACT_READ,    4'd1, 4'd1, 16'h7fff);

        // Random phases over several sizes and idle patterns
        for (p = 0; p < NUM_PHASES; p++) begin
            set_idling(p / 3);
            set_size(phase_sizes[p]);
            run_random_phase(PHASE_ITEMS);
        end

        // Drain and report
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            sb.errors += sb.outstanding();
            $display("%0t: %0d products never returned", $time, sb.outstanding());
        end
        $display("checked %0d product reads after %0d element writes, %0d requests in all",
                 sb.reads_checked, sb.writes_seen, items_sent);
        $display("sizes 0 to 31 incl. clamped ones, under three stall patterns on both streams");
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
